@@ sv/lpht_pkg.sv @@
// shared types and constants of the linear probe hash table
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 64;
	localparam int VAL_W        = 32;
	localparam int SLOT_W       = 4;
	localparam int STATUS_W     = 2;
	localparam int NIB_W        = 4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic probe_start;
		logic probe_step;
		logic reply;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic clr_last;
		logic probe_end;
		logic out_free;
	} sts_t;

endpackage

@@ sv/lpht_if.sv @@
// request and response channel interfaces of the hash table
`timescale 1ns / 1ps

interface lpht_in_if;
	import lpht_pkg::*;
	logic             valid;
	logic             ready;
	logic             mode;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;

	modport source (output valid, output mode, output key, output value, input ready);
	modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lpht_out_if;
	import lpht_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    result_value;
	logic [SLOT_W-1:0]   slot_index;

	modport source (output valid, output status, output result_value, output slot_index,
		input ready);
	modport sink (input valid, input status, input result_value, input slot_index,
		output ready);
endinterface

@@ sv/lpht_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lpht_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ sv/lpht_mod.sv @@
// home slot unit: key modulo capacity, mask or one nibble per cycle
`timescale 1ns / 1ps

module lpht_mod #(
	parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	output logic                          done,
	output logic [$clog2(CAPACITY)-1:0]   rem
);
	import lpht_pkg::*;

	localparam int AW      = $clog2(CAPACITY);
	localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			logic          done_q;
			logic [AW-1:0] rem_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[AW-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end else begin : g_serial
			localparam int TW   = AW + NIB_W;
			localparam int NIBS = KEY_W / NIB_W;
			localparam int CW   = $clog2(NIBS);
			localparam logic [CW-1:0] CNT_LAST = CW'(NIBS - 1);
			localparam logic [TW-1:0] CAP_T    = TW'(CAPACITY);

			logic             busy_q;
			logic             done_q;
			logic [CW-1:0]    cnt_q;
			logic [KEY_W-1:0] key_sh_q;
			logic [AW-1:0]    rem_q;
			logic [TW-1:0]    t;

			// fold in the next nibble, then bring the partial remainder below capacity
			always_comb begin
				t = {rem_q, key_sh_q[KEY_W-1 -: NIB_W]};
				for (int i = NIB_W - 1; i >= 0; i--) begin
					if (t >= (CAP_T << i)) begin
						t = t - (CAP_T << i);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= busy_q && (cnt_q == CNT_LAST);
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_LAST) begin
							busy_q <= 1'b0;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_sh_q <= key;
					rem_q    <= '0;
				end else if (busy_q) begin
					key_sh_q <= key_sh_q << NIB_W;
					rem_q    <= t[AW-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end
	endgenerate
endmodule

@@ sv/lpht_dp.sv @@
// datapath: item registers, home slot unit, slot ram, probe pointer, result and output registers
`timescale 1ns / 1ps

module lpht_dp #(
	parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpht_pkg::cmd_t                  cmd,
	output lpht_pkg::sts_t                  sts,
	input  logic                            mode,
	input  logic [lpht_pkg::KEY_W-1:0]      key,
	input  logic [lpht_pkg::VAL_W-1:0]      value,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [lpht_pkg::STATUS_W-1:0]   status,
	output logic [lpht_pkg::VAL_W-1:0]      result_value,
	output logic [lpht_pkg::SLOT_W-1:0]     slot_index
);
	import lpht_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
	localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);

	logic             mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] ptr_next;

	logic          mod_done;
	logic [AW-1:0] mod_rem;

	entry_t        rd_entry;
	entry_t        wr_entry;
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic          hit;

	logic [STATUS_W-1:0] res_status_q;
	logic [VAL_W-1:0]    res_value_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VAL_W-1:0]    out_value_q;
	logic [SLOT_W-1:0]   out_slot_q;

	logic [AW:0] chk_sum;
	logic [AW:0] chk_wrap;

	lpht_mod #(.CAPACITY(CAPACITY)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.key    (key),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	lpht_ram #(.W($bits(entry_t)), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (wr_entry),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	assign ptr_next  = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign ram_raddr = cmd.probe_start ? mod_rem : ptr_next;

	// insert stops at a free slot, lookup at a valid matching slot
	assign hit = (mode_q == MODE_INSERT) ? !rd_entry.valid
		: (rd_entry.valid && (rd_entry.key == key_q));

	assign ram_we = cmd.clr || (cmd.probe_step && (mode_q == MODE_INSERT) && !rd_entry.valid);

	always_comb begin
		wr_entry = '0;
		if (!cmd.clr) begin
			wr_entry.valid = 1'b1;
			wr_entry.key   = key_q;
			wr_entry.value = value_q;
		end
	end

	assign sts.mod_done  = mod_done;
	assign sts.clr_last  = (ptr_q == LAST);
	assign sts.probe_end = hit || (cnt_q == LAST);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.clr) begin
				ptr_q <= ptr_next;
			end else if (cmd.probe_start) begin
				ptr_q <= mod_rem;
				cnt_q <= '0;
			end else if (cmd.probe_step && !sts.probe_end) begin
				ptr_q <= ptr_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_step && sts.probe_end) begin
			if (hit) begin
				res_status_q <= ST_OK;
				res_slot_q   <= SLOT_W'(ptr_q);
				res_value_q  <= (mode_q == MODE_LOOKUP) ? rd_entry.value : '0;
			end else begin
				res_status_q <= (mode_q == MODE_INSERT) ? ST_FULL : ST_MISS;
				res_slot_q   <= '0;
				res_value_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.reply && sts.out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply && sts.out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = out_status_q;
	assign result_value = out_value_q;
	assign slot_index   = out_slot_q;

	// probe pointer must equal home plus probe count, wrapped at capacity
	always_comb begin
		chk_sum  = {1'b0, mod_rem} + {1'b0, cnt_q};
		chk_wrap = (chk_sum >= CAP_W) ? chk_sum - CAP_W : chk_sum;
	end

	a_ptr_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_step |-> ptr_q == chk_wrap[AW-1:0])
		else $error("probe pointer out of step with probe count");

	a_fail_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q != ST_OK) |-> (out_value_q == '0) && (out_slot_q == '0))
		else $error("failed result beat carries nonzero value or slot");

	a_reply_loads_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reply && sts.out_free |=> out_valid_q)
		else $error("result beat not presented after reply");
endmodule

@@ sv/lpht_ctrl.sv @@
// controller: clearing pass, item sequencing, probe loop and reply
`timescale 1ns / 1ps

module lpht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lpht_pkg::sts_t sts,
	output lpht_pkg::cmd_t cmd
);
	import lpht_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_REPLY = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.mod_done) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.probe_start = 1'b1;
				state_d         = S_CHECK;
			end
			S_CHECK: begin
				cmd.probe_step = 1'b1;
				if (sts.probe_end) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				cmd.reply = 1'b1;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mod_done |-> state_q == S_HASH)
		else $error("home slot ready outside hash state");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |=> state_q != S_CLEAR)
		else $error("clearing pass restarted");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_HASH)
		else $error("accepted beat did not start hashing");
endmodule

@@ sv/linear_probe_hash_table.sv @@
// Open-addressing hash table with linear probing over CAPACITY slots. Each request beat is a
// lookup (mode 0) or an insert (mode 1) of a 64-bit key; each gives exactly one response beat.
// After reset a clearing pass empties all CAPACITY slots, during which no request is taken.
// An accepted item gets its home slot, then probes from it slot by slot until a hit or until
// all CAPACITY slots are probed; its result is then passed to the output register once free.
// The slot RAM has one read port and returns one slot per cycle, and for capacities that are
// not a power of two the home slot is reduced one key nibble per cycle. One item is in work at
// a time; the next is taken while a finished response waits in the output register.
`timescale 1ns / 1ps

module linear_probe_hash_table #(
	parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lpht_in_if.sink    req,
	lpht_out_if.source rsp
);
	import lpht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpht_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (req.mode),
		.key          (req.key),
		.value        (req.value),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.status       (rsp.status),
		.result_value (rsp.result_value),
		.slot_index   (rsp.slot_index)
	);
endmodule

@@ dv/lpht_checker.sv @@
// response checker of the hash table: mirrors the slot table and compares every response beat
`timescale 1ns / 1ps

module lpht_checker
	import lpht_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                req_mode,
	input  logic [KEY_W-1:0]    req_key,
	input  logic [VAL_W-1:0]    req_value,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  logic [STATUS_W-1:0] rsp_status,
	input  logic [VAL_W-1:0]    rsp_result_value,
	input  logic [SLOT_W-1:0]   rsp_slot_index,
	output int                  mismatches,
	output int                  outstanding
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    result_value;
		logic [SLOT_W-1:0]   slot_index;
	} reply_t;

	logic             slot_used [CAPACITY];
	logic [KEY_W-1:0] slot_keys [CAPACITY];
	logic [VAL_W-1:0] slot_vals [CAPACITY];

	reply_t replies_due[$];
	reply_t want;
	reply_t got;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic reply_t probe_table(input logic mode, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		int     home;
		int     s;
		reply_t r;
		home = int'(key % KEY_W'(CAPACITY));
		r.status       = (mode == MODE_LOOKUP) ? ST_MISS : ST_FULL;
		r.result_value = '0;
		r.slot_index   = '0;
		for (int n = 0; n < CAPACITY; n++) begin
			s = (home + n) % CAPACITY;
			if (mode == MODE_LOOKUP) begin
				if (slot_used[s] && slot_keys[s] == key) begin
					r.status       = ST_OK;
					r.result_value = slot_vals[s];
					r.slot_index   = SLOT_W'(s);
					return r;
				end
			end else if (!slot_used[s]) begin
				slot_used[s]   = 1'b1;
				slot_keys[s]   = key;
				slot_vals[s]   = value;
				r.status       = ST_OK;
				r.slot_index   = SLOT_W'(s);
				return r;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_used[i] = 1'b0;
			end
			replies_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got.status       = rsp_status;
				got.result_value = rsp_result_value;
				got.slot_index   = rsp_slot_index;
				if (replies_due.size() == 0) begin
					if (mismatches < 10) begin
						$display("unexpected response beat: status %0d value %h slot %0d",
							got.status, got.result_value, got.slot_index);
					end
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status || got.result_value !== want.result_value ||
						got.slot_index !== want.slot_index) begin
						if (mismatches < 10) begin
							$display("response mismatch: status %0d/%0d value %h/%h slot %0d/%0d",
								want.status, got.status, want.result_value, got.result_value,
								want.slot_index, got.slot_index);
						end
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready) begin
				replies_due.push_back(probe_table(req_mode, req_key, req_value));
			end
			outstanding = replies_due.size();
		end
	end

endmodule

@@ dv/linear_probe_hash_table_tb.sv @@
// testbench top of the hash table: request and response stimulus, checker and verdict
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
	import lpht_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int PHASE_ITEMS = 417;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic hold_start;
	logic hold_rsp;
	int   snd_idle;
	int   rcv_idle;
	int   mismatches;
	int   outstanding;
	int   cycle_count;

	logic [KEY_W-1:0] keys_seen[$];

	lpht_in_if  req_if ();
	lpht_out_if rsp_if ();

	linear_probe_hash_table #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	lpht_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_if.valid),
		.req_ready        (req_if.ready),
		.req_mode         (req_if.mode),
		.req_key          (req_if.key),
		.req_value        (req_if.value),
		.rsp_valid        (rsp_if.valid),
		.rsp_ready        (rsp_if.ready),
		.rsp_status       (rsp_if.status),
		.rsp_result_value (rsp_if.result_value),
		.rsp_slot_index   (rsp_if.slot_index),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// long response stall, counted on its own
	initial begin
		hold_rsp = 1'b0;
		@(posedge hold_start);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp = 1'b0;
	end

	initial rsp_if.ready = 1'b0;

	always @(negedge clk) begin
		rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= rcv_idle);
	end

	task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		while ($urandom_range(99) < snd_idle) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.mode  <= mode;
		req_if.key   <= key;
		req_if.value <= value;
		if (mode == MODE_INSERT) begin
			keys_seen.push_back(key);
		end
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	task automatic random_item();
		int               pick;
		logic [KEY_W-1:0] key;
		pick = $urandom_range(99);
		key  = {$urandom, $urandom};
		if (pick < 45) begin
			key = keys_seen[$urandom_range(keys_seen.size() - 1)];
			send_item(MODE_LOOKUP, key, $urandom);
		end else if (pick < 65) begin
			send_item(MODE_LOOKUP, key, $urandom);
		end else if (pick < 75) begin
			key = keys_seen[$urandom_range(keys_seen.size() - 1)] ^
				(64'd1 << $urandom_range(KEY_W - 1));
			send_item(MODE_LOOKUP, key, $urandom);
		end else begin
			send_item(MODE_INSERT, key, $urandom);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		hold_start   = 1'b0;
		req_if.valid = 1'b0;
		req_if.mode  = MODE_LOOKUP;
		req_if.key   = '0;
		req_if.value = '0;
		snd_idle     = 30;
		rcv_idle     = 88;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table, key zero, wrap, collisions, duplicates
		send_item(MODE_LOOKUP, 64'd0, 32'hFFFF_FFFF);
		send_item(MODE_INSERT, 64'd0, 32'hFFFF_FFFF);
		send_item(MODE_LOOKUP, 64'd0, 32'd0);
		send_item(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		send_item(MODE_INSERT, 64'd16, 32'h1234_5678);
		send_item(MODE_INSERT, 64'd32, 32'hA5A5_5A5A);
		send_item(MODE_INSERT, 64'h8000_0000_0000_000F, 32'h0F0F_F0F0);
		send_item(MODE_LOOKUP, 64'd32, 32'd0);
		send_item(MODE_LOOKUP, 64'h8000_0000_0000_000F, 32'd0);
		send_item(MODE_INSERT, 64'd16, 32'hDEAD_BEEF);
		send_item(MODE_LOOKUP, 64'd16, 32'd0);
		send_item(MODE_LOOKUP, 64'd48, 32'd0);
		// fill the table
		repeat (CAPACITY - 6) send_item(MODE_INSERT, {$urandom, $urandom}, $urandom);
		send_item(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
		send_item(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);

		repeat (PHASE_ITEMS) random_item();
		drain();
		snd_idle = 88;
		rcv_idle = 30;
		@(negedge clk);

		repeat (PHASE_ITEMS) random_item();
		drain();
		snd_idle = 0;
		rcv_idle = 0;
		@(negedge clk);

		hold_start = 1'b1;
		repeat (PHASE_ITEMS) random_item();
		drain();
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/lpht_pkg.sv
sv/lpht_if.sv
sv/lpht_ram.sv
sv/lpht_mod.sv
sv/lpht_dp.sv
sv/lpht_ctrl.sv
sv/linear_probe_hash_table.sv
dv/lpht_checker.sv
dv/linear_probe_hash_table_tb.sv
